/* hw/rtl/tbwl_pkg.sv */
`timescale 1ns / 1ps
package tbwl_pkg;

  localparam int TIME_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int STAT_W      = 32;
  localparam int PERMIT_W    = 16;
  localparam int RATE_W      = 32;
  localparam int BURST_W     = 16;
  localparam int LEN_W       = 16;
  localparam int LEVEL_W     = BURST_W + FRAC_BITS;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = 4;
  localparam int QCNT_W      = 5;
  localparam int PIPE_STAGES = 8;
  localparam int PIPE_CNT_W  = 4;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x < 2^42
  localparam logic [42:0] RECIP_1000  = 43'd4503599627371;
  localparam int          RECIP_SHIFT = 52;

  localparam logic [RATE_W-1:0]  RATE_RESET    = 32'h0001_0000;
  localparam logic [BURST_W-1:0] BURST_RESET   = 16'd1;
  localparam logic [LEN_W-1:0]   WIN_LEN_RESET = 16'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET   = {BURST_RESET, {FRAC_BITS{1'b0}}};

  typedef enum logic {
    MODE_BUCKET = 1'b0,
    MODE_WINDOW = 1'b1
  } tbwl_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_RATE    = 2'd1,
    REG_BURST   = 2'd2,
    REG_WIN_LEN = 2'd3
  } tbwl_reg_t;

  typedef struct packed {
    tbwl_mode_t         mode;
    logic [RATE_W-1:0]  rate;
    logic [BURST_W-1:0] burst;
    logic [LEN_W-1:0]   win_len;
  } tbwl_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now;
    logic [PERMIT_W-1:0] permits;
  } tbwl_tag_t;

  typedef struct packed {
    tbwl_tag_t          tag;
    logic [LEVEL_W-1:0] gain;
  } tbwl_work_t;

endpackage

/* hw/rtl/tbwl_front.sv */
`timescale 1ns / 1ps
module tbwl_front import tbwl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [PERMIT_W-1:0] permit_count,
  input  tbwl_cfg_t           cfg,
  input  logic [QCNT_W-1:0]   q_cnt,
  output logic                q_wr,
  output tbwl_work_t          q_wdata
);

  localparam int E_W    = TIME_W - 1;
  localparam int E_LO_W = 16;
  localparam int E_HI_W = E_W - E_LO_W;
  localparam int PPLO_W = E_LO_W + RATE_W;
  localparam int PPHI_W = E_HI_W + RATE_W;
  localparam int PROD_W = E_W + RATE_W;
  localparam int X_W    = 42;
  localparam int HALF_W = 21;
  localparam int MH_W   = 22;
  localparam int LL_W   = 2 * HALF_W;
  localparam int LH_W   = HALF_W + MH_W;
  localparam int MID_W  = LH_W + 1;
  localparam int LOW_W  = MID_W + HALF_W + 1;
  localparam int TOT_W  = LH_W + 2 * HALF_W;
  localparam int Q_W    = TOT_W - RECIP_SHIFT;

  logic                    accept;
  logic [TIME_W-1:0]       last_r, last_nxt;
  logic [TIME_W-1:0]       elapsed;
  logic                    do_refill;
  logic [E_W-1:0]          e_nxt;
  logic [PIPE_STAGES-1:0]  valid_r;
  tbwl_tag_t               tag_r [PIPE_STAGES];
  logic [PIPE_CNT_W-1:0]   inflight;
  logic [QCNT_W:0]         occ;
  logic [LEVEL_W-1:0]      cap;

  logic [E_W-1:0]          e0_r;
  logic [PPLO_W-1:0]       pplo1_r;
  logic [PPHI_W-1:0]       pphi1_r;
  logic [PROD_W-1:0]       prod2_r;
  logic [X_W-1:0]          x3;
  logic                    sat3_r, sat4_r, sat5_r, sat6_r;
  logic [LL_W-1:0]         ll3_r, ll4_r;
  logic [LH_W-1:0]         lh3_r;
  logic [LL_W-1:0]         hl3_r;
  logic [LH_W-1:0]         hh3_r, hh4_r, hh5_r;
  logic [MID_W-1:0]        mid4_r;
  logic [LOW_W-1:0]        low5_r;
  logic [TOT_W-1:0]        total6;
  logic [Q_W-1:0]          q6_r;
  logic [LEVEL_W-1:0]      gain7_r;

  assign accept = push & ~full;
  assign cap    = {cfg.burst, {FRAC_BITS{1'b0}}};

  // refill only counts when time moved forward (signed view of the wrapped gap)
  always_comb begin
    elapsed   = now_ms - last_r;
    do_refill = accept && (permit_count != '0) && (cfg.mode == MODE_BUCKET) &&
                (elapsed != '0) && !elapsed[TIME_W-1];
    last_nxt  = do_refill ? now_ms : last_r;
    e_nxt     = do_refill ? elapsed[E_W-1:0] : '0;
  end

  // credit: never let more words be in flight than the queue can hold
  always_comb begin
    inflight = PIPE_CNT_W'($countones(valid_r));
    occ      = {1'b0, q_cnt} + (QCNT_W + 1)'(inflight);
    full     = occ >= (QCNT_W + 1)'(QUEUE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      last_r  <= '0;
    end else begin
      valid_r <= {valid_r[PIPE_STAGES-2:0], accept};
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= '{now: now_ms, permits: permit_count};
    for (int i = 1; i < PIPE_STAGES; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
  end

  assign x3     = prod2_r[X_W-1:0];
  assign total6 = {hh5_r, {LL_W{1'b0}}} + TOT_W'(low5_r);

  // gain = min(cap, floor(elapsed * rate / 1000))
  always_ff @(posedge clk) begin
    e0_r    <= e_nxt;
    pplo1_r <= PPLO_W'(e0_r[E_LO_W-1:0]) * PPLO_W'(cfg.rate);
    pphi1_r <= PPHI_W'(e0_r[E_W-1:E_LO_W]) * PPHI_W'(cfg.rate);
    prod2_r <= PROD_W'(pplo1_r) + {pphi1_r, {E_LO_W{1'b0}}};

    // above 2^42 the quotient exceeds any cap
    sat3_r  <= |prod2_r[PROD_W-1:X_W];
    ll3_r   <= LL_W'(x3[HALF_W-1:0]) * LL_W'(RECIP_1000[HALF_W-1:0]);
    lh3_r   <= LH_W'(x3[HALF_W-1:0]) * LH_W'(RECIP_1000[LH_W-1:HALF_W]);
    hl3_r   <= LL_W'(x3[X_W-1:HALF_W]) * LL_W'(RECIP_1000[HALF_W-1:0]);
    hh3_r   <= LH_W'(x3[X_W-1:HALF_W]) * LH_W'(RECIP_1000[LH_W-1:HALF_W]);

    sat4_r  <= sat3_r;
    mid4_r  <= MID_W'(lh3_r) + MID_W'(hl3_r);
    ll4_r   <= ll3_r;
    hh4_r   <= hh3_r;

    sat5_r  <= sat4_r;
    low5_r  <= LOW_W'({mid4_r, {HALF_W{1'b0}}}) + LOW_W'(ll4_r);
    hh5_r   <= hh4_r;

    sat6_r  <= sat5_r;
    q6_r    <= total6[TOT_W-1:RECIP_SHIFT];

    gain7_r <= (sat6_r || (q6_r > Q_W'(cap))) ? cap : q6_r[LEVEL_W-1:0];
  end

  assign q_wr    = valid_r[PIPE_STAGES-1];
  assign q_wdata = '{tag: tag_r[PIPE_STAGES-1], gain: gain7_r};

endmodule

/* hw/rtl/tbwl_queue.sv */
`timescale 1ns / 1ps
module tbwl_queue import tbwl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  tbwl_work_t        wdata,
  input  logic              rd,
  output tbwl_work_t        rdata,
  output logic              empty,
  output logic [QCNT_W-1:0] cnt
);

  tbwl_work_t         mem [QUEUE_DEPTH];
  tbwl_work_t         rdata_r;
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(wr) - QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // head word is registered; a write to the next head slot goes straight through
  always_ff @(posedge clk) begin
    if (wr && (wr_ptr_r == rd_ptr_nxt)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[rd_ptr_nxt];
    end
  end

  assign rdata = rdata_r;
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

endmodule

/* hw/rtl/tbwl_back.sv */
`timescale 1ns / 1ps
module tbwl_back import tbwl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tbwl_cfg_t          cfg,
  input  logic               clamp,
  input  logic               q_empty,
  input  tbwl_work_t         q_rdata,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic               granted,
  output logic [31:0]        available_q16,
  output logic [31:0]        accept_total,
  output logic [31:0]        reject_total
);

  logic                  take;
  logic [PERMIT_W-1:0]   perm;
  logic                  nz;
  logic [LEVEL_W-1:0]    cap;
  logic [LEVEL_W:0]      lvl_sum;
  logic [LEVEL_W-1:0]    lvl_fill;
  logic [LEVEL_W-1:0]    need;
  logic                  ok_tb;
  logic [PERMIT_W-1:0]   lim;
  logic [TIME_W-1:0]     w_gap;
  logic                  expired;
  logic [PERMIT_W-1:0]   used_base;
  logic [PERMIT_W:0]     used_sum;
  logic                  ok_win;
  logic                  ok;
  logic [PERMIT_W-1:0]   left;
  logic [LEVEL_W-1:0]    avail;

  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic [TIME_W-1:0]     win_start_r, win_start_nxt;
  logic [PERMIT_W-1:0]   win_used_r, win_used_nxt;
  logic [STAT_W-1:0]     acc_r, acc_nxt;
  logic [STAT_W-1:0]     rej_r, rej_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  gnt_r;
  logic [LEVEL_W-1:0]    avail_r;

  assign take = !q_empty && (!out_valid_r || pop);
  assign q_rd = take;

  always_comb begin
    perm      = q_rdata.tag.permits;
    nz        = (perm != '0);
    cap       = {cfg.burst, {FRAC_BITS{1'b0}}};

    // bucket: refill with saturation, then take the permits if they fit
    lvl_sum   = {1'b0, level_r} + {1'b0, q_rdata.gain};
    lvl_fill  = (lvl_sum > {1'b0, cap}) ? cap : lvl_sum[LEVEL_W-1:0];
    need      = {perm, {FRAC_BITS{1'b0}}};
    ok_tb     = (lvl_fill >= need);

    // window: restart on expiry, limit is the integer part of the rate
    lim       = cfg.rate[RATE_W-1:FRAC_BITS];
    w_gap     = q_rdata.tag.now - win_start_r;
    expired   = (w_gap >= TIME_W'(cfg.win_len));
    used_base = expired ? '0 : win_used_r;
    used_sum  = {1'b0, used_base} + {1'b0, perm};
    ok_win    = (used_sum <= {1'b0, lim});

    ok = !nz || ((cfg.mode == MODE_WINDOW) ? ok_win : ok_tb);
  end

  always_comb begin
    level_nxt     = level_r;
    win_start_nxt = win_start_r;
    win_used_nxt  = win_used_r;
    acc_nxt       = acc_r;
    rej_nxt       = rej_r;
    if (clamp && (level_r > cap)) begin
      level_nxt = cap;
    end
    if (take && nz) begin
      if (cfg.mode == MODE_WINDOW) begin
        if (expired) begin
          win_start_nxt = q_rdata.tag.now;
        end
        win_used_nxt = ok_win ? used_sum[PERMIT_W-1:0] : used_base;
      end else begin
        level_nxt = ok_tb ? (lvl_fill - need) : lvl_fill;
      end
      if (ok) begin
        acc_nxt = acc_r + 1'b1;
      end else begin
        rej_nxt = rej_r + 1'b1;
      end
    end
  end

  always_comb begin
    left  = (win_used_nxt >= lim) ? '0 : (lim - win_used_nxt);
    avail = (cfg.mode == MODE_WINDOW) ? {left, {FRAC_BITS{1'b0}}} : level_nxt;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LEVEL_RESET;
      win_start_r <= '0;
      win_used_r  <= '0;
      acc_r       <= '0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      win_start_r <= win_start_nxt;
      win_used_r  <= win_used_nxt;
      acc_r       <= acc_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      gnt_r   <= ok;
      avail_r <= avail;
    end
  end

  // totals only move when a new word is loaded, so they track the output word
  assign empty         = !out_valid_r;
  assign granted       = gnt_r;
  assign available_q16 = avail_r;
  assign accept_total  = acc_r;
  assign reject_total  = rej_r;

endmodule

/* hw/rtl/token_bucket_window_limiter_unit.sv */
// A word accepted on push passes the 8-stage refill multiply/divide-by-1000
// pipeline, the queue write and the result register to reach the result side.
// Throughput: one word per cycle on both sides while pop is held; push sees full
// only when the 16-entry queue plus refill pipeline words would run out of room.
// Reset (rst_n low, synchronous): registers back to their defaults, bucket full
// at one permit, window, timestamps and totals cleared, queue and result empty.
`timescale 1ns / 1ps
module token_bucket_window_limiter_unit import tbwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           in_now_ms,
  input  logic [15:0]           in_permit_count,
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_granted,
  output logic [31:0]           out_available_q16,
  output logic [31:0]           out_accept_total,
  output logic [31:0]           out_reject_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tbwl_cfg_t          cfg_r, cfg_nxt;
  logic               clamp_r, clamp_nxt;
  logic               q_wr;
  logic               q_rd;
  logic               q_empty;
  tbwl_work_t         q_wdata;
  tbwl_work_t         q_rdata;
  logic [QCNT_W-1:0]  q_cnt;

  // zero writes to rate, burst and window length are dropped
  always_comb begin
    cfg_nxt   = cfg_r;
    clamp_nxt = 1'b0;
    if (cfg_we) begin
      case (tbwl_reg_t'(cfg_index))
        REG_MODE: begin
          cfg_nxt.mode = tbwl_mode_t'(cfg_wdata[0]);
        end
        REG_RATE: begin
          if (cfg_wdata[RATE_W-1:0] != '0) begin
            cfg_nxt.rate = cfg_wdata[RATE_W-1:0];
            clamp_nxt    = 1'b1;
          end
        end
        REG_BURST: begin
          if (cfg_wdata[BURST_W-1:0] != '0) begin
            cfg_nxt.burst = cfg_wdata[BURST_W-1:0];
            clamp_nxt     = 1'b1;
          end
        end
        REG_WIN_LEN: begin
          if (cfg_wdata[LEN_W-1:0] != '0) begin
            cfg_nxt.win_len = cfg_wdata[LEN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '{mode: MODE_BUCKET, rate: RATE_RESET, burst: BURST_RESET,
                   win_len: WIN_LEN_RESET};
      clamp_r <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  tbwl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .now_ms       (in_now_ms),
    .permit_count (in_permit_count),
    .cfg          (cfg_r),
    .q_cnt        (q_cnt),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  tbwl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty),
    .cnt   (q_cnt)
  );

  tbwl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .clamp         (clamp_r),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .granted       (out_granted),
    .available_q16 (out_available_q16),
    .accept_total  (out_accept_total),
    .reject_total  (out_reject_total)
  );

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> (q_cnt != QCNT_W'(QUEUE_DEPTH)))
    else $error("refill pipeline wrote a word into a full queue");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("back end read an empty queue");

  a_full_covers_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == QCNT_W'(QUEUE_DEPTH)) |-> full)
    else $error("push open while the queue is full");
`endif

endmodule

/* verif/tbwl_grant_checker.sv */
`timescale 1ns / 1ps
module tbwl_grant_checker import tbwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  logic [31:0]           in_now_ms,
  input  logic [15:0]           in_permit_count,
  input  logic                  empty,
  input  logic                  pop,
  input  logic                  out_granted,
  input  logic [31:0]           out_available_q16,
  input  logic [31:0]           out_accept_total,
  input  logic [31:0]           out_reject_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending_count
);

  typedef struct packed {
    logic        granted;
    logic [31:0] avail;
    logic [31:0] accepts;
    logic [31:0] rejects;
  } grant_word_t;

  tbwl_mode_t         mode_r;
  logic [RATE_W-1:0]  rate_r;
  logic [BURST_W-1:0] burst_r;
  logic [LEN_W-1:0]   win_len_r;
  logic [63:0]        level;
  logic [TIME_W-1:0]  last_refill;
  logic [TIME_W-1:0]  win_start;
  logic [15:0]        win_used;
  logic [STAT_W-1:0]  accepts;
  logic [STAT_W-1:0]  rejects;

  grant_word_t pending_grants[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic [63:0] bucket_cap();
    return 64'(burst_r) << FRAC_BITS;
  endfunction

  function automatic void log_fault(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic grant_word_t decide_request(logic [31:0] now, logic [15:0] permits);
    grant_word_t w;
    logic [31:0] elapsed;
    logic [31:0] since_start;
    logic [63:0] cap;
    logic [63:0] whole_s;
    logic [63:0] frac_ms;
    logic [63:0] gain;
    logic [63:0] need;
    logic [15:0] win_limit;
    logic [15:0] left;
    logic        ok;
    ok        = 1'b1;
    cap       = bucket_cap();
    win_limit = 16'(rate_r >> FRAC_BITS);
    if (permits != 16'd0) begin
      if (mode_r == MODE_BUCKET) begin
        elapsed = now - last_refill;
        // refill only when time moved forward (signed view of the wrapped delta)
        if (elapsed != 32'd0 && !elapsed[31]) begin
          whole_s = 64'(elapsed) / 64'd1000;
          frac_ms = 64'(elapsed) % 64'd1000;
          if (whole_s != 64'd0 && whole_s > cap / 64'(rate_r)) begin
            gain = cap;
          end else begin
            gain = whole_s * 64'(rate_r) + (frac_ms * 64'(rate_r)) / 64'd1000;
            if (gain > cap) gain = cap;
          end
          level = level + gain;
          if (level > cap) level = cap;
          last_refill = now;
        end
        need = 64'(permits) << FRAC_BITS;
        ok   = level >= need;
        if (ok) level = level - need;
      end else begin
        since_start = now - win_start;
        if (since_start >= 32'(win_len_r)) begin
          win_start = now;
          win_used  = 16'd0;
        end
        ok = 32'(win_used) + 32'(permits) <= 32'(win_limit);
        if (ok) win_used = win_used + permits;
      end
      if (ok) accepts = accepts + 1'b1;
      else rejects = rejects + 1'b1;
    end
    left      = (win_used >= win_limit) ? 16'd0 : win_limit - win_used;
    w.granted = ok;
    w.avail   = (mode_r == MODE_BUCKET) ? level[31:0] : 32'(left) << FRAC_BITS;
    w.accepts = accepts;
    w.rejects = rejects;
    return w;
  endfunction

  always @(posedge clk) begin
    grant_word_t got;
    grant_word_t want;
    if (!rst_n) begin
      mode_r      = MODE_BUCKET;
      rate_r      = RATE_RESET;
      burst_r     = BURST_RESET;
      win_len_r   = WIN_LEN_RESET;
      level       = 64'(LEVEL_RESET);
      last_refill = '0;
      win_start   = '0;
      win_used    = '0;
      accepts     = '0;
      rejects     = '0;
      pending_grants.delete();
    end else begin
      if (cfg_we) begin
        // zero writes to rate, burst and window length are dropped
        case (tbwl_reg_t'(cfg_index))
          REG_MODE:    mode_r = tbwl_mode_t'(cfg_wdata[0]);
          REG_RATE:    if (cfg_wdata != '0) rate_r = cfg_wdata[RATE_W-1:0];
          REG_BURST:   if (cfg_wdata[BURST_W-1:0] != '0) burst_r = cfg_wdata[BURST_W-1:0];
          REG_WIN_LEN: if (cfg_wdata[LEN_W-1:0] != '0) win_len_r = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
        if (level > bucket_cap()) level = bucket_cap();
      end
      if (push && !full) pending_grants.push_back(decide_request(in_now_ms, in_permit_count));
      if (pop && !empty) begin
        got = {out_granted, out_available_q16, out_accept_total, out_reject_total};
        if (pending_grants.size() == 0) begin
          log_fault($sformatf("unexpected word: granted=%0b avail=%h acc=%0d rej=%0d",
                              got.granted, got.avail, got.accepts, got.rejects));
        end else begin
          want = pending_grants.pop_front();
          if (got.granted !== want.granted || got.avail !== want.avail ||
              got.accepts !== want.accepts || got.rejects !== want.rejects) begin
            log_fault($sformatf({"mismatch: granted %0b/%0b avail %h/%h ",
                                 "acc %0d/%0d rej %0d/%0d (expected/actual)"},
                                want.granted, got.granted, want.avail, got.avail,
                                want.accepts, got.accepts, want.rejects, got.rejects));
          end
        end
      end
    end
    pending_count = pending_grants.size();
  end

endmodule

/* verif/token_bucket_window_limiter_unit_test.sv */
`timescale 1ns / 1ps
module token_bucket_window_limiter_unit_test;
  import tbwl_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  pop;
  logic [31:0]           in_now_ms;
  logic [15:0]           in_permit_count;
  logic                  cfg_we;
  tbwl_reg_t             cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  full;
  logic                  empty;
  logic                  out_granted;
  logic [31:0]           out_available_q16;
  logic [31:0]           out_accept_total;
  logic [31:0]           out_reject_total;
  int                    mismatch_count;
  int                    pending_count;

  token_bucket_window_limiter_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_now_ms         (in_now_ms),
    .in_permit_count   (in_permit_count),
    .empty             (empty),
    .pop               (pop),
    .out_granted       (out_granted),
    .out_available_q16 (out_available_q16),
    .out_accept_total  (out_accept_total),
    .out_reject_total  (out_reject_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  tbwl_grant_checker grant_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_now_ms         (in_now_ms),
    .in_permit_count   (in_permit_count),
    .empty             (empty),
    .pop               (pop),
    .out_granted       (out_granted),
    .out_available_q16 (out_available_q16),
    .out_accept_total  (out_accept_total),
    .out_reject_total  (out_reject_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: pops with a stall style that is re-picked at random during the run
  initial begin
    int stall_left;
    int rx_cycle;
    int rx_style;
    pop        = 1'b0;
    stall_left = 0;
    rx_cycle   = 0;
    rx_style   = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 100 == 0) rx_style = $urandom_range(0, 2);
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        case (rx_style)
          1:       stall_left = $urandom_range(0, 1) ? $urandom_range(1, 2) : 0;
          2:       stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 0;
          default: stall_left = 0;
        endcase
      end
    end
  end

  task automatic write_reg(input tbwl_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drive at a falling edge, return at the falling edge after acceptance
  task automatic send_word(input logic [31:0] now, input logic [15:0] permits);
    in_now_ms       = now;
    in_permit_count = permits;
    push            = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // drain all outstanding words before touching registers
  task automatic settle();
    push = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    logic [31:0] clock_ms;
    logic [31:0] rate;
    logic [15:0] burst;
    logic [15:0] win_len;
    logic [15:0] permits;
    int          step_hi;
    int          permit_hi;
    int          burst_left;
    int          pick;

    rst_n           = 1'b0;
    push            = 1'b0;
    in_now_ms       = '0;
    in_permit_count = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_MODE;
    cfg_wdata       = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: bucket of one permit, one permit per second
    send_word(32'd0, 16'd0);
    send_word(32'd0, 16'd1);
    send_word(32'd0, 16'd1);
    send_word(32'd999, 16'd1);
    send_word(32'd1000, 16'd1);
    send_word(32'd400, 16'd1);                 // time goes backwards
    send_word(32'h8000_03E8, 16'hFFFF);        // delta with sign bit set
    send_word(32'h7FFF_FFFF, 16'd1);           // huge refill saturates
    send_word(32'hFFFF_FFFF, 16'd0);

    settle();
    write_reg(REG_BURST, 32'd0);               // zero writes are dropped
    write_reg(REG_RATE, 32'd0);
    write_reg(REG_WIN_LEN, 32'd0);
    write_reg(REG_BURST, 32'd65535);
    write_reg(REG_RATE, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 16'hFFFF);
    send_word(32'hC000_0000, 16'd1);
    send_word(32'hC000_0001, 16'hFFFF);
    send_word(32'h0000_0005, 16'd1);           // forward across the wrap

    settle();
    write_reg(REG_BURST, 32'd1);               // level clamps to new burst
    write_reg(REG_RATE, 32'd1);
    send_word(32'd6, 16'd1);
    send_word(32'd2006, 16'd1);

    settle();
    write_reg(REG_MODE, 32'(MODE_WINDOW));
    write_reg(REG_RATE, 32'h0003_8000);
    write_reg(REG_WIN_LEN, 32'd1);
    send_word(32'd100, 16'd2);
    send_word(32'd100, 16'd2);
    send_word(32'd100, 16'd1);
    send_word(32'd101, 16'd1);

    settle();
    write_reg(REG_WIN_LEN, 32'd65535);
    write_reg(REG_RATE, 32'hFFFF_FFFF);
    send_word(32'd200, 16'hFFFF);
    send_word(32'd200 + 32'd65535, 16'hFFFF);

    settle();
    write_reg(REG_RATE, 32'h0000_FFFF);        // integer rate zero
    send_word(32'd300000, 16'd1);
    send_word(32'd300000, 16'd0);

    settle();
    write_reg(REG_MODE, 32'(MODE_BUCKET));     // state carries over
    send_word(32'd300001, 16'd1);

    clock_ms   = 32'd300001;
    burst_left = 0;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      write_reg(REG_MODE, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 7))
        0:       rate = 32'hFFFF_FFFF;
        1:       rate = 32'd1;
        2:       rate = 32'd0;
        3:       rate = $urandom;
        4:       rate = $urandom_range(1, 65535);
        default: rate = ($urandom_range(1, 40) << FRAC_BITS) | $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0:       burst = 16'd65535;
        1:       burst = 16'd1;
        2:       burst = 16'd0;
        default: burst = 16'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       win_len = 16'd65535;
        1:       win_len = 16'd1;
        2:       win_len = 16'd0;
        default: win_len = 16'($urandom_range(1, 400));
      endcase
      write_reg(REG_RATE, rate);
      write_reg(REG_BURST, 32'(burst));
      write_reg(REG_WIN_LEN, 32'(win_len));
      case ($urandom_range(0, 3))
        0:       step_hi = 3;
        1:       step_hi = 60;
        2:       step_hi = 600;
        default: step_hi = 3000;
      endcase
      permit_hi = $urandom_range(1, 12);

      for (int n = 0; n < 183; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
          end
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 85) clock_ms = clock_ms + $urandom_range(0, step_hi);
        else if (pick < 90) clock_ms = clock_ms - $urandom_range(0, 2000);
        else if (pick < 95) clock_ms = clock_ms + $urandom;
        else clock_ms = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10) permits = 16'd0;
        else if (pick < 85) permits = 16'($urandom_range(1, permit_hi));
        else if (pick < 95) permits = 16'($urandom_range(1, 65535));
        else permits = 16'hFFFF;
        send_word(clock_ms, permits);
      end
    end

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* token_bucket_window_limiter_unit.f */
hw/rtl/tbwl_pkg.sv
hw/rtl/tbwl_front.sv
hw/rtl/tbwl_queue.sv
hw/rtl/tbwl_back.sv
hw/rtl/token_bucket_window_limiter_unit.sv
verif/tbwl_grant_checker.sv
verif/token_bucket_window_limiter_unit_test.sv
